[hw/rtl/psp_pkg.sv]
// psp_pkg: shared types and constants for the pkcs1 signature padding checker
// no dependencies; compiled before the interfaces and all modules
`default_nettype none

package psp_pkg;

	// fixed field widths
	localparam int POS_W = 9;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;
	localparam int HDR_WORD_BYTES = 8;
	localparam int HDR_STORED_BYTES = 24;
	localparam logic [POS_W-1:0] POS_LIMIT = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_LEN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIG_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_A = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HDR_C = 3'd5;

	// expected padding bytes
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE = 8'h01;
	localparam logic [7:0] BYTE_FILL = 8'hFF;

	// item kinds
	localparam logic KIND_DIGEST = 1'b0;
	localparam logic KIND_SIG = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_PAD = 2'd1,
		STATUS_DIGEST = 2'd2
	} status_t;

	// effective configuration, clamped
	typedef struct packed {
		logic [7:0] sep;
		logic [5:0] hdr_len;
		logic [5:0] dig_len;
		logic [8*HDR_STORED_BYTES-1:0] hdr;
	} cfg_t;

	// signature byte in flight between classify and verdict
	typedef struct packed {
		logic last;
		logic is_digest;
		logic pad_mis;
		status_t short_st;
		logic [7:0] data;
	} sig_t;

endpackage

`default_nettype wire

[hw/rtl/psp_if.sv]
// psp_if: valid/ready channel interfaces for items, results and config writes
// uses psp_pkg for field widths
`default_nettype none

interface psp_item_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] data_byte;
	logic last;
	modport source (output valid, kind, data_byte, last, input ready);
	modport sink (input valid, kind, data_byte, last, output ready);
endinterface

interface psp_result_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	modport source (output valid, status, input ready);
	modport sink (input valid, status, output ready);
endinterface

interface psp_cfg_if;
	logic valid;
	logic ready;
	logic [psp_pkg::CFG_IDX_W-1:0] index;
	logic [psp_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/psp_cfg_regs.sv]
// psp_cfg_regs: configuration register file with clamped effective values
// depends on psp_pkg and psp_cfg_if
`default_nettype none

module psp_cfg_regs #(
	parameter int MAX_DIGEST_BYTES = 32,
	parameter int MAX_HEADER_BYTES = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,
	psp_cfg_if.sink   cfg,
	output psp_pkg::cfg_t cfg_eff
);
	import psp_pkg::*;

	localparam logic [5:0] HDR_MAX = 6'(MAX_HEADER_BYTES);
	localparam logic [6:0] DIG_MAX = 7'(MAX_DIGEST_BYTES);

	logic [7:0] sep_q;
	logic [4:0] hdr_len_q;
	logic [5:0] dig_len_q;
	logic [CFG_DATA_W-1:0] hdr_a_q;
	logic [CFG_DATA_W-1:0] hdr_b_q;
	logic [CFG_DATA_W-1:0] hdr_c_q;

	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= 8'd204;
			hdr_len_q <= 5'd19;
			dig_len_q <= 6'd32;
			hdr_a_q <= '0;
			hdr_b_q <= '0;
			hdr_c_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SEPARATOR: sep_q <= cfg.data[7:0];
				REG_HDR_LEN: hdr_len_q <= cfg.data[4:0];
				REG_DIG_LEN: dig_len_q <= cfg.data[5:0];
				REG_HDR_A: hdr_a_q <= cfg.data;
				REG_HDR_B: hdr_b_q <= cfg.data;
				REG_HDR_C: hdr_c_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// clamp to the supported ranges
	always_comb begin
		cfg_eff.sep = (sep_q < 8'd2) ? 8'd2 : sep_q;
		cfg_eff.hdr_len = ({1'b0, hdr_len_q} > HDR_MAX) ? HDR_MAX : {1'b0, hdr_len_q};
		cfg_eff.dig_len = ({1'b0, dig_len_q} > DIG_MAX) ? DIG_MAX[5:0] : dig_len_q;
		cfg_eff.hdr = {hdr_a_q, hdr_b_q, hdr_c_q};
	end

endmodule

`default_nettype wire

[hw/rtl/psp_classify.sv]
// psp_classify: byte position tracking, digest store and per-byte layout check
// depends on psp_pkg and psp_item_if
`default_nettype none

module psp_classify #(
	parameter int MAX_BLOCK_BYTES = 256,
	parameter int MAX_DIGEST_BYTES = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	psp_item_if.sink  item,
	input  wire psp_pkg::cfg_t cfg_eff,
	input  wire logic advance,
	output logic sig_valid_s1,
	output psp_pkg::sig_t sig_s1,
	output logic [7:0] digest_s1
);
	import psp_pkg::*;

	localparam int AW = $clog2(MAX_DIGEST_BYTES);
	localparam int LW = AW + 1;
	localparam logic [LW-1:0] LOAD_FULL = LW'(MAX_DIGEST_BYTES);
	localparam logic [9:0] BLK_END = 10'(MAX_BLOCK_BYTES);

	logic [7:0] digest_mem [MAX_DIGEST_BYTES];
	logic [POS_W-1:0] pos_q;
	logic [LW-1:0] load_idx_q;

	logic accept;
	logic [9:0] p_ext;
	logic [9:0] hdr_start;
	logic [9:0] dig_start;
	logic [9:0] lay_end;
	logic [9:0] hdr_off;
	logic [9:0] dig_off;
	logic [9:0] end_v;
	logic [7:0] hbyte [HDR_STORED_BYTES];
	logic [7:0] expect_byte;
	logic in_pad;
	logic in_dig;
	sig_t sig_d;

	assign item.ready = !sig_valid_s1 || advance;
	assign accept = item.valid && item.ready;

	// header bytes, lowest number in the top bits
	always_comb begin
		for (int i = 0; i < HDR_STORED_BYTES; i++) begin
			hbyte[i] = cfg_eff.hdr[8*(HDR_STORED_BYTES-1-i) +: 8];
		end
	end

	// layout boundaries and region of the current position
	always_comb begin
		p_ext = {1'b0, pos_q};
		hdr_start = {2'b0, cfg_eff.sep} + 10'd1;
		dig_start = hdr_start + {4'b0, cfg_eff.hdr_len};
		lay_end = dig_start + {4'b0, cfg_eff.dig_len};
		hdr_off = p_ext - hdr_start;
		dig_off = p_ext - dig_start;
		in_pad = 1'b1;
		in_dig = 1'b0;
		expect_byte = BYTE_ZERO;
		if (p_ext >= BLK_END) begin
			in_pad = 1'b0;
		end else if (p_ext == 10'd0) begin
			expect_byte = BYTE_ZERO;
		end else if (p_ext == 10'd1) begin
			expect_byte = BYTE_ONE;
		end else if (p_ext < {2'b0, cfg_eff.sep}) begin
			expect_byte = BYTE_FILL;
		end else if (p_ext == {2'b0, cfg_eff.sep}) begin
			expect_byte = BYTE_ZERO;
		end else if (p_ext < dig_start) begin
			expect_byte = (hdr_off < 10'(HDR_STORED_BYTES)) ? hbyte[hdr_off[4:0]] : BYTE_ZERO;
		end else begin
			in_pad = 1'b0;
			in_dig = dig_off < {4'b0, cfg_eff.dig_len};
		end
		// short block: first missing byte decides the class
		end_v = (p_ext + 10'd1 > BLK_END) ? BLK_END : p_ext + 10'd1;
		sig_d.last = item.last;
		sig_d.is_digest = in_dig;
		sig_d.pad_mis = in_pad && (item.data_byte != expect_byte);
		sig_d.data = item.data_byte;
		if (end_v >= lay_end) begin
			sig_d.short_st = STATUS_OK;
		end else if (end_v < dig_start) begin
			sig_d.short_st = STATUS_PAD;
		end else begin
			sig_d.short_st = STATUS_DIGEST;
		end
	end

	// position and load counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			load_idx_q <= '0;
			sig_valid_s1 <= 1'b0;
		end else begin
			if (advance) begin
				sig_valid_s1 <= 1'b0;
			end
			if (accept) begin
				if (item.kind == KIND_DIGEST) begin
					if (load_idx_q != LOAD_FULL) begin
						load_idx_q <= load_idx_q + LW'(1);
					end
				end else begin
					sig_valid_s1 <= 1'b1;
					if (item.last) begin
						pos_q <= '0;
						load_idx_q <= '0;
					end else if (pos_q != POS_LIMIT) begin
						pos_q <= pos_q + POS_W'(1);
					end
				end
			end
		end
	end

	// digest store: write on load beats, registered read on signature beats
	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_DIGEST && load_idx_q != LOAD_FULL) begin
			digest_mem[load_idx_q[AW-1:0]] <= item.data_byte;
		end
		if (accept && item.kind == KIND_SIG) begin
			digest_s1 <= digest_mem[dig_off[AW-1:0]];
			sig_s1 <= sig_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/psp_verdict.sv]
// psp_verdict: sticky verdict update and registered status output
// depends on psp_pkg and psp_result_if
`default_nettype none

module psp_verdict (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic sig_valid_s1,
	input  wire psp_pkg::sig_t sig_s1,
	input  wire logic [7:0] digest_s1,
	output logic advance,
	psp_result_if.source result
);
	import psp_pkg::*;

	status_t verdict_q;
	status_t status_q;
	status_t verdict_d;
	logic out_valid_q;

	assign result.valid = out_valid_q;
	assign result.status = status_q;

	// a beat without result always retires; a last beat needs room in the output
	assign advance = sig_valid_s1 && (!sig_s1.last || !out_valid_q || result.ready);

	// first mismatch wins
	always_comb begin
		verdict_d = verdict_q;
		if (verdict_q == STATUS_OK) begin
			if (sig_s1.is_digest && (digest_s1 != sig_s1.data)) begin
				verdict_d = STATUS_DIGEST;
			end else if (sig_s1.pad_mis) begin
				verdict_d = STATUS_PAD;
			end
		end
		if (sig_s1.last && verdict_d == STATUS_OK) begin
			verdict_d = sig_s1.short_st;
		end
	end

	// verdict and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q <= STATUS_OK;
			status_q <= STATUS_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				if (sig_s1.last) begin
					verdict_q <= STATUS_OK;
					status_q <= verdict_d;
					out_valid_q <= 1'b1;
				end else begin
					verdict_q <= verdict_d;
				end
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pkcs1_signature_padding_check.sv]
// pkcs1_signature_padding_check: top level of the pkcs1 v1.5 signature padding checker
// depends on psp_pkg, psp_if, psp_cfg_regs, psp_classify, psp_verdict
//
//   channel | dir | payload                     | beat
//   cfg     | in  | index[2:0], data[63:0]      | one register write
//   item    | in  | kind, data_byte[7:0], last  | one digest or signature byte
//   result  | out | status[1:0]                 | one verdict per signature block
//
// one item per cycle sustained unless the output stalls; a signature byte
// passes stage s1, which holds the registered digest store read, before the verdict
// digest loads finish at their beat; the store is written and read once a cycle
// reset clears counters and verdict; the digest store holds no reset value
// item.ready drops only while a last byte waits for a full, stalled output register
`default_nettype none

module pkcs1_signature_padding_check #(
	parameter int MAX_BLOCK_BYTES = 256,
	parameter int MAX_DIGEST_BYTES = 32,
	parameter int MAX_HEADER_BYTES = 24
) (
	input wire logic clk,
	input wire logic arst_n,
	psp_cfg_if.sink cfg,
	psp_item_if.sink item,
	psp_result_if.source result
);
	import psp_pkg::*;

	cfg_t cfg_eff;
	sig_t sig_s1;
	logic sig_valid_s1;
	logic [7:0] digest_s1;
	logic advance;

	// configuration registers
	psp_cfg_regs #(
		.MAX_DIGEST_BYTES(MAX_DIGEST_BYTES),
		.MAX_HEADER_BYTES(MAX_HEADER_BYTES)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.cfg_eff(cfg_eff)
	);

	// position tracking and digest store
	psp_classify #(
		.MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
		.MAX_DIGEST_BYTES(MAX_DIGEST_BYTES)
	) u_classify (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg_eff(cfg_eff),
		.advance(advance),
		.sig_valid_s1(sig_valid_s1),
		.sig_s1(sig_s1),
		.digest_s1(digest_s1)
	);

	// verdict and status output
	psp_verdict u_verdict (
		.clk(clk),
		.arst_n(arst_n),
		.sig_valid_s1(sig_valid_s1),
		.sig_s1(sig_s1),
		.digest_s1(digest_s1),
		.advance(advance),
		.result(result)
	);

endmodule

`default_nettype wire

[tb/sv/padding_verdict_checker.sv]
// padding_verdict_checker: watches the config, item and result channels of the padding checker,
// predicts one status per signature block and compares it with each result beat
// depends on psp_pkg and the channel interfaces in psp_if
module padding_verdict_checker #(
	parameter int MAX_BLOCK_BYTES = 256,
	parameter int MAX_DIGEST_BYTES = 32,
	parameter int MAX_HEADER_BYTES = 24
) (
	input logic clk,
	input logic arst_n,
	input logic drain_done,
	psp_cfg_if cfg,
	psp_item_if item,
	psp_result_if result,
	output int failures,
	output int pending
);
	import psp_pkg::*;

	localparam logic [7:0] SEP_AT_RESET = 8'd204;
	localparam logic [4:0] HLEN_AT_RESET = 5'd19;
	localparam logic [5:0] DLEN_AT_RESET = 6'd32;

	// register copies
	logic [7:0] sep_reg;
	logic [4:0] hlen_reg;
	logic [5:0] dlen_reg;
	logic [63:0] hword [0:2];

	// block progress
	int position;
	int load_count;
	logic [7:0] digest_copy [0:MAX_DIGEST_BYTES-1];
	status_t block_verdict;
	status_t expected_status [$];

	initial begin
		failures = 0;
		pending = 0;
	end

	task automatic report(input string what, input int got, input int want);
		failures++;
		$display("mismatch at %0t: %s, got %0d, want %0d", $time, what, got, want);
	endtask

	// clamped settings
	function automatic int sep_eff();
		return (sep_reg < 8'd2) ? 2 : int'(sep_reg);
	endfunction

	function automatic int hlen_eff();
		return (int'(hlen_reg) > MAX_HEADER_BYTES) ? MAX_HEADER_BYTES : int'(hlen_reg);
	endfunction

	function automatic int dlen_eff();
		return (int'(dlen_reg) > MAX_DIGEST_BYTES) ? MAX_DIGEST_BYTES : int'(dlen_reg);
	endfunction

	// header byte i, lowest byte of each word in its top bits; past the stored words it reads zero
	function automatic logic [7:0] header_at(input int i);
		if (i >= 3 * HDR_WORD_BYTES)
			return BYTE_ZERO;
		return hword[i / HDR_WORD_BYTES][63 - 8 * (i % HDR_WORD_BYTES) -: 8];
	endfunction

	// mismatch class of one signature byte at its position
	function automatic status_t byte_class(input int p, input logic [7:0] b);
		int s;
		int hl;
		int dl;
		int k;
		s = sep_eff();
		hl = hlen_eff();
		dl = dlen_eff();
		if (p == 0)
			return (b == BYTE_ZERO) ? STATUS_OK : STATUS_PAD;
		if (p == 1)
			return (b == BYTE_ONE) ? STATUS_OK : STATUS_PAD;
		if (p < s)
			return (b == BYTE_FILL) ? STATUS_OK : STATUS_PAD;
		if (p == s)
			return (b == BYTE_ZERO) ? STATUS_OK : STATUS_PAD;
		if (p <= s + hl)
			return (b == header_at(p - s - 1)) ? STATUS_OK : STATUS_PAD;
		k = p - s - 1 - hl;
		if (k < dl)
			return (b == digest_copy[k]) ? STATUS_OK : STATUS_DIGEST;
		return STATUS_OK;
	endfunction

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_SEPARATOR: sep_reg = value[7:0];
			REG_HDR_LEN: hlen_reg = value[4:0];
			REG_DIG_LEN: dlen_reg = value[5:0];
			REG_HDR_A: hword[0] = value;
			REG_HDR_B: hword[1] = value;
			REG_HDR_C: hword[2] = value;
			default: ;
		endcase
	endtask

	// one accepted item: digest load, or signature byte that may close the block
	task automatic absorb_item(input logic k, input logic [7:0] b, input logic l);
		int hdr_end;
		int lay_end;
		int end_pos;
		if (k == KIND_DIGEST) begin
			if (load_count < MAX_DIGEST_BYTES) begin
				digest_copy[load_count] = b;
				load_count++;
			end
			return;
		end
		if (block_verdict == STATUS_OK && position < MAX_BLOCK_BYTES)
			block_verdict = byte_class(position, b);
		if (!l) begin
			if (position < int'(POS_LIMIT))
				position++;
			return;
		end
		// a block ending early fails on its first missing byte
		if (block_verdict == STATUS_OK) begin
			end_pos = (position + 1 > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : position + 1;
			hdr_end = sep_eff() + 1 + hlen_eff();
			lay_end = hdr_end + dlen_eff();
			if (end_pos < lay_end)
				block_verdict = (end_pos < hdr_end) ? STATUS_PAD : STATUS_DIGEST;
		end
		expected_status.push_back(block_verdict);
		position = 0;
		load_count = 0;
		block_verdict = STATUS_OK;
	endtask

	// sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		status_t want;
		if (!arst_n) begin
			sep_reg = SEP_AT_RESET;
			hlen_reg = HLEN_AT_RESET;
			dlen_reg = DLEN_AT_RESET;
			hword[0] = '0;
			hword[1] = '0;
			hword[2] = '0;
			position = 0;
			load_count = 0;
			block_verdict = STATUS_OK;
			expected_status.delete();
		end else begin
			if (result.valid && result.ready) begin
				if (expected_status.size() == 0) begin
					report("status beat with no block closed", int'(result.status), -1);
				end else begin
					want = expected_status.pop_front();
					if (result.status !== want)
						report("status", int'(result.status), int'(want));
				end
			end
			if (cfg.valid && cfg.ready)
				apply_write(cfg.index, cfg.data);
			if (item.valid && item.ready)
				absorb_item(item.kind, item.data_byte, item.last);
		end
		pending = expected_status.size();
	end

	// blocks still owed a status once the run has drained
	always @(posedge drain_done) begin
		if (expected_status.size() != 0)
			report("blocks left without status", expected_status.size(), 0);
	end

endmodule

[tb/sv/testbench.sv]
// testbench: drives config writes and digest/signature bytes into the padding checker,
// stalls the status channel, and prints the verdict from the checker's failure count
// depends on psp_pkg, psp_if, pkcs1_signature_padding_check and padding_verdict_checker
module testbench;
	import psp_pkg::*;

	localparam int MAX_BLOCK = 256;
	localparam int MAX_DIGEST = 32;
	localparam int MAX_HEADER = 24;
	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES = 600000;
	localparam int RANDOM_ITEMS = 1900;
	localparam int RANDOM_BLOCKS = 48;
	localparam int PHASE_ITEMS = 200;
	localparam int LONG_BLOCK = 520;
	localparam int PRESSURE_BLOCKS = 25;
	localparam int PAUSE_PHASE = 4;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// receiver stall patterns
	localparam int RX_OPEN = 0;
	localparam int RX_COIN = 1;
	localparam int RX_THIRD = 2;
	localparam int RX_SPARSE = 3;

	typedef enum int {SHAPE_GOOD, SHAPE_FLIP, SHAPE_SHORT, SHAPE_NOISE, SHAPE_LONG} shape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic drain_done = 1'b0;
	int failures;
	int pending;

	psp_cfg_if cfg_ch ();
	psp_item_if item_ch ();
	psp_result_if result_ch ();

	// settings as written, for building well-formed blocks
	int sep_set;
	int hlen_set;
	int dlen_set;
	logic [7:0] hdr_bytes [0:3*HDR_WORD_BYTES-1];
	logic [7:0] dig_bytes [0:MAX_DIGEST-1];
	int loads_sent = 0;
	int written_prefix = 0;

	// sender pacing
	int burst_left = 0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int items_sent = 0;
	int blocks_sent = 0;

	always #HALF_PERIOD clk = ~clk;

	pkcs1_signature_padding_check #(
		.MAX_BLOCK_BYTES(MAX_BLOCK),
		.MAX_DIGEST_BYTES(MAX_DIGEST),
		.MAX_HEADER_BYTES(MAX_HEADER)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.item(item_ch),
		.result(result_ch)
	);

	padding_verdict_checker #(
		.MAX_BLOCK_BYTES(MAX_BLOCK),
		.MAX_DIGEST_BYTES(MAX_DIGEST),
		.MAX_HEADER_BYTES(MAX_HEADER)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.drain_done(drain_done),
		.cfg(cfg_ch),
		.item(item_ch),
		.result(result_ch),
		.failures(failures),
		.pending(pending)
	);

	function automatic int lim_sep();
		return (sep_set < 2) ? 2 : sep_set;
	endfunction

	function automatic int lim_hlen();
		return (hlen_set > MAX_HEADER) ? MAX_HEADER : hlen_set;
	endfunction

	function automatic int lim_dlen();
		return (dlen_set > MAX_DIGEST) ? MAX_DIGEST : dlen_set;
	endfunction

	// well-formed byte for position p; anything past the layout is random
	function automatic logic [7:0] padded_byte(input int p);
		int s;
		int hl;
		int dl;
		int k;
		s = lim_sep();
		hl = lim_hlen();
		dl = lim_dlen();
		if (p == 0)
			return BYTE_ZERO;
		if (p == 1)
			return BYTE_ONE;
		if (p < s)
			return BYTE_FILL;
		if (p == s)
			return BYTE_ZERO;
		if (p <= s + hl)
			return hdr_bytes[p - s - 1];
		k = p - s - 1 - hl;
		if (k < dl)
			return dig_bytes[k];
		return 8'($urandom);
	endfunction

	function automatic logic [63:0] random_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic shape_t pick_shape();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return SHAPE_GOOD;
		if (r < 75)
			return SHAPE_FLIP;
		if (r < 87)
			return SHAPE_SHORT;
		return SHAPE_NOISE;
	endfunction

	// one item beat, with burst gaps unless the sender runs steady
	task automatic put_item(input logic k, input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				item_ch.valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		if (k == KIND_DIGEST) begin
			if (loads_sent < MAX_DIGEST) begin
				dig_bytes[loads_sent] = b;
				loads_sent++;
				items_sent++;
				if (loads_sent > written_prefix)
					written_prefix = loads_sent;
			end
		end else begin
			items_sent++;
			if (l) begin
				loads_sent = 0;
				blocks_sent++;
			end
		end
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.data_byte <= b;
		item_ch.last <= l;
		do
			@(posedge clk);
		while (!item_ch.ready);
	endtask

	task automatic drop_valid();
		@(negedge clk);
		item_ch.valid <= 1'b0;
	endtask

	// wait for every status, then, if settle is set, let the pipeline empty before any register write
	task automatic go_idle(input bit settle);
		drop_valid();
		while (pending != 0)
			@(negedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		case (idx)
			REG_SEPARATOR: sep_set = int'(value[7:0]);
			REG_HDR_LEN: hlen_set = int'(value[4:0]);
			REG_DIG_LEN: dlen_set = int'(value[5:0]);
			REG_HDR_A, REG_HDR_B, REG_HDR_C: begin
				for (int j = 0; j < HDR_WORD_BYTES; j++)
					hdr_bytes[(int'(idx) - int'(REG_HDR_A)) * HDR_WORD_BYTES + j] =
						value[63 - 8 * j -: 8];
			end
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// full setting; upper data bits are random so masking gets exercised
	task automatic write_setting(input int sep, input int hl, input int dl,
			input logic [63:0] wa, input logic [63:0] wb, input logic [63:0] wc);
		logic [63:0] v;
		v = {$urandom, $urandom};
		v[7:0] = 8'(sep);
		write_reg(REG_SEPARATOR, v);
		v = {$urandom, $urandom};
		v[4:0] = 5'(hl);
		write_reg(REG_HDR_LEN, v);
		v = {$urandom, $urandom};
		v[5:0] = 6'(dl);
		write_reg(REG_DIG_LEN, v);
		write_reg(REG_HDR_A, wa);
		write_reg(REG_HDR_B, wb);
		write_reg(REG_HDR_C, wc);
	endtask

	task automatic load_digest(input int n);
		for (int i = 0; i < n; i++)
			put_item(KIND_DIGEST, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// signature bytes of one block; flip_at corrupts one byte, mid_at slips in a digest load
	task automatic send_layout(input int len, input int flip_at, input int mid_at, input bit noise);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			if (i == mid_at)
				put_item(KIND_DIGEST, 8'($urandom), 1'($urandom_range(0, 1)));
			b = noise ? 8'($urandom) : padded_byte(i);
			if (i == flip_at)
				b = b ^ 8'($urandom_range(1, 255));
			put_item(KIND_SIG, b, i == len - 1);
		end
	endtask

	task automatic send_block(input shape_t shape);
		int lay;
		int len;
		int flip_at;
		int mid_at;
		lay = lim_sep() + 1 + lim_hlen() + lim_dlen();
		// the store must hold every digest byte this block can reach
		if (written_prefix < lim_dlen() || $urandom_range(0, 3) == 0)
			load_digest(lim_dlen() + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 0));
		flip_at = -1;
		case (shape)
			SHAPE_GOOD: len = lay + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
			SHAPE_FLIP: begin
				len = lay + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
				flip_at = $urandom_range(0, len - 1);
			end
			SHAPE_SHORT: len = $urandom_range(1, lay - 1);
			SHAPE_NOISE: len = $urandom_range(1, 12);
			default: len = LONG_BLOCK;
		endcase
		mid_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
		send_layout(len, flip_at, mid_at, shape == SHAPE_NOISE);
	endtask

	task automatic set_phase(input int n);
		int sep;
		int hl;
		int dl;
		int r;
		case (n)
			0: write_setting(255, 31, 63, '1, '1, {$urandom, $urandom});
			1: write_setting(2, 0, 0, '0, '0, '0);
			2: write_setting(1, MAX_HEADER, MAX_DIGEST, random_word(), random_word(), random_word());
			3: begin
				write_reg(REG_SPARE_LO, {$urandom, $urandom});
				write_reg(REG_SPARE_HI, {$urandom, $urandom});
				write_setting(0, 25, 33, random_word(), random_word(), random_word());
			end
			default: begin
				r = $urandom_range(0, 9);
				sep = (r == 0) ? $urandom_range(100, 255) :
					(r == 1) ? $urandom_range(0, 1) : $urandom_range(2, 20);
				hl = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 31) : $urandom_range(0, 24);
				dl = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 32);
				write_setting(sep, hl, dl, random_word(), random_word(), random_word());
			end
		endcase
	endtask

	// status receiver: changing stall patterns, plus one long hold-off on request
	initial begin : receiver
		int tick;
		int hold_left;
		int mode;
		tick = 0;
		hold_left = 0;
		mode = RX_OPEN;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					hold_done = 1'b1;
			end else if (hold_req && !hold_done) begin
				result_ch.ready <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
			end else begin
				if (tick % 97 == 0)
					mode = $urandom_range(RX_OPEN, RX_SPARSE);
				case (mode)
					RX_OPEN: result_ch.ready <= 1'b1;
					RX_COIN: result_ch.ready <= 1'($urandom_range(0, 1));
					RX_THIRD: result_ch.ready <= (tick % 3 == 0);
					default: result_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin
		#(LIMIT_CYCLES * 2 * HALF_PERIOD);
		$display("CHECKS FAILED");
		$finish;
	end

	// stimulus
	initial begin : stimulus
		int phase;
		int phase_start;
		int item_base;
		int block_base;
		bit paused;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_DIGEST;
		item_ch.data_byte = '0;
		item_ch.last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_SEPARATOR;
		cfg_ch.data = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// directed: tiny layout 00 01 00 h0 h1 d0 d1 with a separator below the minimum
		write_setting(0, 2, 2, {$urandom, $urandom}, random_word(), random_word());
		put_item(KIND_DIGEST, 8'h00, 1'b1);
		put_item(KIND_DIGEST, 8'hFF, 1'b0);
		send_layout(7, -1, -1, 1'b0);
		send_layout(1, 0, -1, 1'b0);
		send_layout(7, 6, -1, 1'b0);
		send_layout(4, -1, -1, 1'b0);
		send_layout(6, -1, -1, 1'b0);

		// random phases, each under its own setting
		item_base = items_sent;
		block_base = blocks_sent;
		paused = 1'b0;
		phase = 0;
		while (items_sent - item_base < RANDOM_ITEMS || blocks_sent - block_base < RANDOM_BLOCKS) begin
			go_idle(1'b1);
			set_phase(phase);
			steady = ($urandom_range(0, 3) == 0);
			phase_start = items_sent;
			case (phase)
				0: begin
					send_block(SHAPE_LONG);
					send_block(SHAPE_GOOD);
				end
				1: begin
					// output held off while short blocks keep coming back to back
					steady = 1'b1;
					@(posedge clk);
					hold_req = 1'b1;
					repeat (PRESSURE_BLOCKS) send_block(SHAPE_GOOD);
					drop_valid();
					while (!hold_done)
						@(negedge clk);
					steady = 1'b0;
				end
				2: load_digest(MAX_DIGEST + 2);
				default: ;
			endcase
			while (items_sent - phase_start < PHASE_ITEMS) begin
				send_block(pick_shape());
				if (phase == PAUSE_PHASE && !paused) begin
					go_idle(1'b0);
					paused = 1'b1;
				end
			end
			phase++;
		end

		// drain and verdict
		go_idle(1'b1);
		drain_done = 1'b1;
		@(negedge clk);
		@(negedge clk);
		if (failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/psp_pkg.sv
hw/rtl/psp_if.sv
hw/rtl/psp_cfg_regs.sv
hw/rtl/psp_classify.sv
hw/rtl/psp_verdict.sv
hw/rtl/pkcs1_signature_padding_check.sv
tb/sv/padding_verdict_checker.sv
tb/sv/testbench.sv
